FILE: rtl/iac_pkg.sv
// Shared types and codes for the integer calculator ALU.
// Operation and status codes, controller command and datapath status bundles.
// No dependencies.
package iac_pkg;

   typedef enum logic [2:0] {
      FN_ADD    = 3'd0,
      FN_SUB    = 3'd1,
      FN_MUL    = 3'd2,
      FN_DIV    = 3'd3,
      FN_SQUARE = 3'd4,
      FN_CUBE   = 3'd5,
      FN_ROOT   = 3'd6,
      FN_FACT   = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DIV_ZERO  = 2'd1,
      ST_ROOT_NEG  = 2'd2
   } status_type;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;
   localparam int DIGIT_W  = 8;

   typedef struct packed {
      logic load;
      logic mul_start;
      logic mul_again;
      logic mul_step;
      logic div_start;
      logic div_step;
      logic sqrt_start;
      logic sqrt_step;
      logic fact_start;
      logic fact_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     a_neg;
      logic     b_zero;
      logic     fact_done;
   } dp_status_type;

endpackage

FILE: rtl/iac_ctrl.sv
// Controller state machine of the integer calculator ALU.
// Sequences the datapath through each operation and owns the result valid flag.
// Depends on iac_pkg.
module iac_ctrl import iac_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   localparam int CNT_W      = $clog2(DATA_WIDTH);
   localparam int MUL_STEPS  = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
   localparam int SQRT_STEPS = DATA_WIDTH / 2;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DISPATCH = 8'b0000_0010,
      S_MUL      = 8'b0000_0100,
      S_CUBE     = 8'b0000_1000,
      S_DIV      = 8'b0001_0000,
      S_SQRT     = 8'b0010_0000,
      S_FACT     = 8'b0100_0000,
      S_FINISH   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cube_ff, cube_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cube_in      = cube_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cnt_in = '0;
            case (sts.func)
               FN_ADD, FN_SUB: begin
                  state_in = S_FINISH;
               end
               FN_MUL, FN_SQUARE, FN_CUBE: begin
                  cmd.mul_start = 1'b1;
                  cube_in       = (sts.func == FN_CUBE);
                  state_in      = S_MUL;
               end
               FN_DIV: begin
                  if (sts.b_zero) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               FN_ROOT: begin
                  if (sts.a_neg) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.sqrt_start = 1'b1;
                     state_in       = S_SQRT;
                  end
               end
               FN_FACT: begin
                  cmd.fact_start = 1'b1;
                  state_in       = S_FACT;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = cube_ff ? S_CUBE : S_FINISH;
            end
         end
         S_CUBE: begin
            cmd.mul_again = 1'b1;
            cube_in       = 1'b0;
            state_in      = S_MUL;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FACT: begin
            if (sts.fact_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.fact_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cube_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cube_ff      <= cube_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/iac_datapath.sv
// Datapath of the integer calculator ALU: operand registers, digit-serial multiplier,
// radix-2 divider, bit-pair square root, factorial accumulator and result register.
// Depends on iac_pkg.
module iac_datapath import iac_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   input  dp_cmd_type            cmd,
   output dp_status_type         sts,
   output logic [DATA_WIDTH-1:0] rsp_result,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int W        = DATA_WIDTH;
   localparam int IDX_W    = $clog2(DATA_WIDTH + 4);
   localparam int SQ_SHIFT = DATA_WIDTH % 2;

   func_type      func_ff;
   logic [W-1:0]  a_ff, b_ff;
   logic [W-1:0]  mc_ff, mc_in;
   logic [W-1:0]  sh_ff, sh_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W+1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [W-1:0]  out_data_ff, out_data_in;
   status_type    out_status_ff, out_status_in;

   logic          a_neg, b_neg, b_zero;
   logic [W-1:0]  a_mag, b_mag;
   logic [W+DIGIT_W-1:0] mul_part;
   logic [W+IDX_W-1:0]   fact_prod;
   logic [W:0]    div_sh;
   logic [W+1:0]  div_diff;
   logic [W+1:0]  sq_sh;
   logic [W+2:0]  sq_diff;
   logic [W-1:0]  quot;

   assign a_neg  = a_ff[W-1];
   assign b_neg  = b_ff[W-1];
   assign b_zero = (b_ff == '0);
   assign a_mag  = a_neg ? (~a_ff + W'(1)) : a_ff;
   assign b_mag  = b_neg ? (~b_ff + W'(1)) : b_ff;

   assign mul_part  = {{DIGIT_W{1'b0}}, mc_ff} * {{W{1'b0}}, sh_ff[DIGIT_W-1:0]};
   assign fact_prod = {{IDX_W{1'b0}}, acc_ff} * {{W{1'b0}}, idx_ff};

   assign div_sh   = {rem_ff[W-1:0], sh_ff[W-1]};
   assign div_diff = {1'b0, div_sh} - {2'b00, mc_ff};

   assign sq_sh   = {rem_ff[W-1:0], sh_ff[W-1:W-2]};
   assign sq_diff = {1'b0, sq_sh} - {1'b0, acc_ff, 2'b01};

   assign quot = (a_neg ^ b_neg) ? (~sh_ff + W'(1)) : sh_ff;

   assign sts.func      = func_ff;
   assign sts.a_neg     = a_neg;
   assign sts.b_zero    = b_zero;
   assign sts.fact_done = a_neg || (acc_ff == '0) ||
                          ({{(W-IDX_W){1'b0}}, idx_ff} > a_ff);

   assign rsp_result = out_data_ff;
   assign rsp_status = out_status_ff;

   always_comb begin
      mc_in  = mc_ff;
      sh_in  = sh_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (cmd.mul_start) begin
         acc_in = '0;
         mc_in  = a_ff;
         sh_in  = (func_ff == FN_MUL) ? b_ff : a_ff;
      end
      if (cmd.mul_again) begin
         acc_in = '0;
         mc_in  = a_ff;
         sh_in  = acc_ff;
      end
      if (cmd.mul_step) begin
         acc_in = acc_ff + mul_part[W-1:0];
         mc_in  = mc_ff << DIGIT_W;
         sh_in  = sh_ff >> DIGIT_W;
      end
      if (cmd.div_start) begin
         rem_in = '0;
         sh_in  = a_mag;
         mc_in  = b_mag;
      end
      if (cmd.div_step) begin
         if (div_diff[W+1]) begin
            rem_in = {1'b0, div_sh};
            sh_in  = {sh_ff[W-2:0], 1'b0};
         end else begin
            rem_in = div_diff;
            sh_in  = {sh_ff[W-2:0], 1'b1};
         end
      end
      if (cmd.sqrt_start) begin
         rem_in = '0;
         acc_in = '0;
         sh_in  = a_ff << SQ_SHIFT;
      end
      if (cmd.sqrt_step) begin
         rem_in = sq_diff[W+2] ? sq_sh : sq_diff[W+1:0];
         acc_in = {acc_ff[W-2:0], ~sq_diff[W+2]};
         sh_in  = sh_ff << 2;
      end
      if (cmd.fact_start) begin
         acc_in = W'(1);
         idx_in = IDX_W'(1);
      end
      if (cmd.fact_step) begin
         acc_in = fact_prod[W-1:0];
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      out_status_in = ST_OK;
      case (func_ff)
         FN_ADD:    out_data_in = a_ff + b_ff;
         FN_SUB:    out_data_in = a_ff - b_ff;
         FN_DIV: begin
            if (b_zero) begin
               out_data_in   = '0;
               out_status_in = ST_DIV_ZERO;
            end else begin
               out_data_in = quot;
            end
         end
         FN_ROOT: begin
            if (a_neg) begin
               out_data_in   = '0;
               out_status_in = ST_ROOT_NEG;
            end else begin
               out_data_in = acc_ff;
            end
         end
         default:   out_data_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         a_ff    <= req_operand_a;
         b_ff    <= req_operand_b;
      end
      mc_ff  <= mc_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
      if (cmd.out_load) begin
         out_data_ff   <= out_data_in;
         out_status_ff <= out_status_in;
      end
   end

endmodule

FILE: rtl/integer_calculator_alu.sv
// Integer calculator ALU: add, sub, mul, div, square, cube, floor root, factorial.
// Divide by zero and the root of a negative operand skip the iterative step; factorial
// stops once the index passes n or the product reaches zero, which at W=32 happens
// after 34 multiply steps.
// One item in flight; the next beat is taken once the result sits in the output register.
// Synchronous active-high reset clears the controller and result valid; data is not reset.
module integer_calculator_alu import iac_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // operand_a, operand_b, zero fill
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   req_tdata,
   // func
   input  logic [FUNC_W-1:0]                   req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result, zero fill
   output logic [((DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   // status
   output logic [STATUS_W-1:0]                 rsp_tuser
);

   localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

   dp_cmd_type            cmd;
   dp_status_type         sts;
   logic [DATA_WIDTH-1:0] result;

   assign rsp_tdata = OUT_W'(result);

   iac_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   iac_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .req_func      (req_tuser),
      .req_operand_a (req_tdata[DATA_WIDTH-1:0]),
      .req_operand_b (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_result    (result),
      .rsp_status    (rsp_tuser)
   );

endmodule
